// File: design/lse_pkg.sv
// ----------------------------------------------------------------------------
// LED strip effect engine package
// Shared types, register map and constants of the LED strip effect engine.
// ----------------------------------------------------------------------------
package lse_pkg;

  // Widths fixed by the register map and the result fields.
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int CH_W      = 8;
  localparam int COLOR_W   = 3 * CH_W;
  localparam int IDX_W     = 4;
  localparam int IVL_W     = 16;
  localparam int STRIP_W   = 5;
  localparam int MAX_LEDS_DEF = 16;

  // Effect constants.
  localparam logic [CH_W-1:0] FADE_STEP = 8'd15;
  localparam logic [CH_W-1:0] FULL      = 8'hFF;
  localparam logic [CH_W-1:0] FADE_RST  = 8'd4;
  localparam logic [CH_W-1:0] BLINK_RST = 8'd1;

  // Register reset values.
  localparam logic [CH_W-1:0]    BRIGHT_RST = 8'd255;
  localparam logic [IVL_W-1:0]   IVL_RST    = 16'd50;
  localparam logic [CH_W-1:0]    PERIOD_RST = 8'd5;
  localparam logic [STRIP_W-1:0] STRIP_RST  = 5'd9;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_ON    = 2'd1,
    MODE_BLINK = 2'd2,
    MODE_FADE  = 2'd3
  } lse_mode_t;

  // Register index, taken from the word address.
  typedef enum logic [2:0] {
    REG_MODE     = 3'd0,
    REG_COLOR    = 3'd1,
    REG_BRIGHT   = 3'd2,
    REG_INTERVAL = 3'd3,
    REG_PERIOD   = 3'd4,
    REG_STRIP    = 3'd5
  } lse_reg_t;

  typedef struct packed {
    lse_mode_t            effect_mode;
    logic [COLOR_W-1:0]   base_color;
    logic [CH_W-1:0]      brightness;
    logic [IVL_W-1:0]     update_interval;
    logic [CH_W-1:0]      blink_period;
    logic [STRIP_W-1:0]   strip_length;
  } lse_cfg_t;

  // Frame request from the effect logic to the LED sender.
  typedef struct packed {
    logic               start;
    logic [COLOR_W-1:0] color;
  } lse_frame_t;

endpackage

// File: design/lse_apb_regs.sv
// ----------------------------------------------------------------------------
// LED strip effect engine register file
// APB-style register block holding the effect configuration.
// ----------------------------------------------------------------------------
module lse_apb_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lse_pkg::ADDR_W-1:0] paddr,
  input  logic [lse_pkg::DATA_W-1:0] pwdata,
  output logic [lse_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output lse_pkg::lse_cfg_t          cfg
);
  import lse_pkg::*;

  lse_cfg_t cfg_r;
  lse_cfg_t cfg_nxt;
  lse_reg_t reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = lse_reg_t'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  // Write decode.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        REG_MODE:     cfg_nxt.effect_mode     = lse_mode_t'(pwdata[1:0]);
        REG_COLOR:    cfg_nxt.base_color      = pwdata[COLOR_W-1:0];
        REG_BRIGHT:   cfg_nxt.brightness      = pwdata[CH_W-1:0];
        REG_INTERVAL: cfg_nxt.update_interval = pwdata[IVL_W-1:0];
        REG_PERIOD:   cfg_nxt.blink_period    = pwdata[CH_W-1:0];
        REG_STRIP:    cfg_nxt.strip_length    = pwdata[STRIP_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.effect_mode     <= MODE_OFF;
      cfg_r.base_color      <= '0;
      cfg_r.brightness      <= BRIGHT_RST;
      cfg_r.update_interval <= IVL_RST;
      cfg_r.blink_period    <= PERIOD_RST;
      cfg_r.strip_length    <= STRIP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux, values zero-extended to the bus width.
  always_comb begin
    case (reg_sel)
      REG_MODE:     prdata = DATA_W'(cfg_r.effect_mode);
      REG_COLOR:    prdata = DATA_W'(cfg_r.base_color);
      REG_BRIGHT:   prdata = DATA_W'(cfg_r.brightness);
      REG_INTERVAL: prdata = DATA_W'(cfg_r.update_interval);
      REG_PERIOD:   prdata = DATA_W'(cfg_r.blink_period);
      REG_STRIP:    prdata = DATA_W'(cfg_r.strip_length);
      default:      prdata = '0;
    endcase
  end

endmodule

// File: design/lse_effect.sv
// ----------------------------------------------------------------------------
// LED strip effect engine effect logic
// Tick counter and per-update color computation for all effect modes.
// ----------------------------------------------------------------------------
module lse_effect (
  input  logic                clk,
  input  logic                rst_n,
  input  lse_pkg::lse_cfg_t   cfg,
  input  logic                tick_step,
  output logic                upd_due,
  output lse_pkg::lse_frame_t frame
);
  import lse_pkg::*;

  logic [IVL_W-1:0]   ticks_r, ticks_nxt;
  logic [CH_W-1:0]    fade_r, fade_nxt;
  logic               rising_r, rising_nxt;
  logic [CH_W-1:0]    blink_cnt_r, blink_cnt_nxt;
  logic               lit_r, lit_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;
  logic               start;

  logic [CH_W-1:0]    cut;
  logic [CH_W-1:0]    dim_r, dim_g, dim_b;
  logic [COLOR_W-1:0] dimmed;
  logic [CH_W:0]      fade_sum;
  logic [CH_W-1:0]    fade_lvl;
  logic               fade_dir;
  logic [CH_W-1:0]    scale;
  logic [2*CH_W-1:0]  prod_r, prod_g, prod_b;
  logic [CH_W-1:0]    blink_dec;

  assign upd_due     = (ticks_r == '0);
  assign start       = tick_step && upd_due;
  assign frame.start = start;
  assign frame.color = color_r;

  // Dimming: each channel minus (255 - brightness), floored at zero.
  assign cut   = ~cfg.brightness;
  assign dim_r = (cfg.base_color[23:16] > cut) ? cfg.base_color[23:16] - cut : '0;
  assign dim_g = (cfg.base_color[15:8]  > cut) ? cfg.base_color[15:8]  - cut : '0;
  assign dim_b = (cfg.base_color[7:0]   > cut) ? cfg.base_color[7:0]   - cut : '0;
  assign dimmed = {dim_r, dim_g, dim_b};

  // Fade level step with clamping and direction turn at the ends.
  assign fade_sum = {1'b0, fade_r} + {1'b0, FADE_STEP};
  always_comb begin
    fade_lvl = fade_r;
    fade_dir = rising_r;
    if (rising_r) begin
      if (fade_sum >= {1'b0, FULL}) begin
        fade_lvl = FULL;
        fade_dir = 1'b0;
      end else begin
        fade_lvl = fade_sum[CH_W-1:0];
      end
    end else begin
      if (fade_r <= FADE_STEP) begin
        fade_lvl = '0;
        fade_dir = 1'b1;
      end else begin
        fade_lvl = fade_r - FADE_STEP;
      end
    end
  end

  // Scale the dimmed color by (255 - level), keeping the high byte.
  assign scale  = ~fade_lvl;
  assign prod_r = dim_r * scale;
  assign prod_g = dim_g * scale;
  assign prod_b = dim_b * scale;

  assign blink_dec = blink_cnt_r - 8'd1;

  // Next state on an accepted tick.
  always_comb begin
    ticks_nxt     = ticks_r;
    fade_nxt      = fade_r;
    rising_nxt    = rising_r;
    blink_cnt_nxt = blink_cnt_r;
    lit_nxt       = lit_r;
    color_nxt     = color_r;
    if (tick_step) begin
      if (!upd_due) begin
        ticks_nxt = ticks_r - 16'd1;
      end else begin
        ticks_nxt = (cfg.update_interval == '0) ? '0 : cfg.update_interval - 16'd1;
        case (cfg.effect_mode)
          MODE_ON: begin
            color_nxt = dimmed;
          end
          MODE_BLINK: begin
            if (blink_dec == '0) begin
              blink_cnt_nxt = cfg.blink_period;
              lit_nxt       = !lit_r;
              color_nxt     = lit_r ? '0 : dimmed;
            end else begin
              blink_cnt_nxt = blink_dec;
            end
          end
          MODE_FADE: begin
            fade_nxt   = fade_lvl;
            rising_nxt = fade_dir;
            color_nxt  = {prod_r[2*CH_W-1:CH_W], prod_g[2*CH_W-1:CH_W],
                          prod_b[2*CH_W-1:CH_W]};
          end
          default: begin
            color_nxt = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r     <= '0;
      fade_r      <= FADE_RST;
      rising_r    <= 1'b1;
      blink_cnt_r <= BLINK_RST;
      lit_r       <= 1'b0;
      color_r     <= '0;
    end else begin
      ticks_r     <= ticks_nxt;
      fade_r      <= fade_nxt;
      rising_r    <= rising_nxt;
      blink_cnt_r <= blink_cnt_nxt;
      lit_r       <= lit_nxt;
      color_r     <= color_nxt;
    end
  end

endmodule

// File: design/lse_frame_tx.sv
// ----------------------------------------------------------------------------
// LED strip effect engine frame sender
// Emits the shared color once per LED of the strip through an output register.
// ----------------------------------------------------------------------------
module lse_frame_tx #(
  parameter int MAX_LEDS = lse_pkg::MAX_LEDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lse_pkg::lse_frame_t         frame,
  input  logic [lse_pkg::STRIP_W-1:0] strip_length,
  output logic                        busy,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lse_pkg::IDX_W-1:0]   out_led_index,
  output logic [lse_pkg::CH_W-1:0]    out_red,
  output logic [lse_pkg::CH_W-1:0]    out_green,
  output logic [lse_pkg::CH_W-1:0]    out_blue,
  output logic                        out_last
);
  import lse_pkg::*;

  localparam int CntW = $clog2(MAX_LEDS + 1);

  logic [CntW-1:0]    len_r, len_nxt;
  logic [CntW-1:0]    idx_r, idx_nxt;
  logic [CntW-1:0]    len_sat;
  logic               load;
  logic               vld_r, vld_nxt;
  logic [IDX_W-1:0]   index_r;
  logic [COLOR_W-1:0] color_r;
  logic               last_r;

  // Strip length saturated to the LED count the sender supports.
  assign len_sat = (32'(strip_length) > 32'(MAX_LEDS)) ? CntW'(MAX_LEDS)
                                                       : CntW'(strip_length);

  assign busy = (idx_r != len_r);
  assign load = busy && (!vld_r || out_ready);

  // LED counter: a frame start loads the length, each loaded beat advances.
  always_comb begin
    len_nxt = len_r;
    idx_nxt = idx_r;
    if (frame.start) begin
      len_nxt = len_sat;
      idx_nxt = '0;
    end else if (load) begin
      idx_nxt = idx_r + CntW'(1);
    end
    vld_nxt = load || (vld_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      len_r <= len_nxt;
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      index_r <= IDX_W'(idx_r);
      color_r <= frame.color;
      last_r  <= (idx_r + CntW'(1) == len_r);
    end
  end

  assign out_valid     = vld_r;
  assign out_led_index = index_r;
  assign out_red       = color_r[23:16];
  assign out_green     = color_r[15:8];
  assign out_blue      = color_r[7:0];
  assign out_last      = last_r;

endmodule

// File: design/led_strip_effect_engine.sv
// ----------------------------------------------------------------------------
// LED strip effect engine
// Throughput: one tick beat per cycle while in_ready is high; an updating tick
// sends strip_length beats, capped at MAX_LEDS, one per cycle unless out_ready
// stalls, and the next updating tick waits until the last is in the output register.
// Reset is synchronous, active low, and restores all state but the output payload.
// ----------------------------------------------------------------------------
module led_strip_effect_engine #(
  parameter int MAX_LEDS = lse_pkg::MAX_LEDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lse_pkg::ADDR_W-1:0] paddr,
  input  logic [lse_pkg::DATA_W-1:0] pwdata,
  output logic [lse_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_tick,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lse_pkg::IDX_W-1:0]  out_led_index,
  output logic [lse_pkg::CH_W-1:0]   out_red,
  output logic [lse_pkg::CH_W-1:0]   out_green,
  output logic [lse_pkg::CH_W-1:0]   out_blue,
  output logic                       out_last
);
  import lse_pkg::*;

  lse_cfg_t   cfg;
  lse_frame_t frame;
  logic       upd_due;
  logic       tx_busy;
  logic       tick_step;

  // A tick that would start a frame waits while the sender still has LEDs.
  assign in_ready  = !tx_busy || !upd_due;
  assign tick_step = in_valid && in_ready && in_tick;

  lse_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lse_effect u_effect (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .tick_step (tick_step),
    .upd_due   (upd_due),
    .frame     (frame)
  );

  lse_frame_tx #(
    .MAX_LEDS (MAX_LEDS)
  ) u_tx (
    .clk           (clk),
    .rst_n         (rst_n),
    .frame         (frame),
    .strip_length  (cfg.strip_length),
    .busy          (tx_busy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_led_index (out_led_index),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_last      (out_last)
  );

endmodule
